@@ hw/rtl/gwm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gwm_pkg
// Shared types and constants of the block wear and garbage-collection manager.
// ----------------------------------------------------------------------------
package gwm_pkg;

	// Request codes
	localparam logic [1:0] REQ_WRITE  = 2'd0;
	localparam logic [1:0] REQ_ALLOC  = 2'd1;
	localparam logic [1:0] REQ_VICTIM = 2'd2;
	localparam logic [1:0] REQ_RETIRE = 2'd3;

	// Configuration register indexes
	localparam logic CFG_TOTAL = 1'b0;
	localparam logic CFG_ERASE = 1'b1;

	localparam int unsigned DIV_NW = 40;
	localparam int unsigned DIV_DW = 17;
	localparam logic [31:0] SCORE_MAX = 32'hFFFF_FFFF;
	localparam logic [20:0] ERASE_RESET = 21'd4096;

	typedef struct packed {
		logic [15:0] wear;
		logic [20:0] live;
		logic [20:0] dead;
		logic        bad;
		logic        rsv;
		logic        ret;
	} entry_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} mem_ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/gwm_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gwm_div
// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module gwm_div import gwm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIV_NW-1:0] num,
	input  wire logic [DIV_DW-1:0] den,
	output logic                   done,
	output logic [DIV_NW-1:0]      quot
);

	localparam int unsigned CW = $clog2(DIV_NW + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_NW-1:0] quot_q;
	logic [DIV_DW:0]   trial;
	logic              ge;
	logic [DIV_DW:0]   diff;

	always_comb begin
		trial = {rem_q, quot_q[DIV_NW-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(DIV_NW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			den_q  <= den;
			quot_q <= num;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
			quot_q <= {quot_q[DIV_NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
`default_nettype wire

@@ hw/rtl/gwm_tbl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gwm_tbl
// Block table memory, one address for reads and writes, registered read data.
// Clears all entries after reset, one per cycle.
// ----------------------------------------------------------------------------
module gwm_tbl import gwm_pkg::*; #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mem_ctl_t      ctl,
	input  wire logic [AW-1:0] addr,
	input  wire entry_t        wdata,
	output entry_t             rdata,
	output logic               clearing
);

	entry_t      mem_q [DEPTH];
	entry_t      rdata_q;
	logic [AW:0] clr_q;

	assign clearing = clr_q < (AW+1)'(DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing) begin
			mem_q[clr_q[AW-1:0]] <= '0;
		end else if (ctl.wr) begin
			mem_q[addr] <= wdata;
		end
		// hold read data between reads
		if (ctl.rd) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ hw/rtl/flash_block_wear_gc_manager_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// flash_block_wear_gc_manager_unit
// Per-block wear table with allocate, GC victim pick, retire and entry write.
//
// Requests enter on in_valid/in_stall; one result per request leaves on
// out_valid/out_stall through an output register, so a result may wait while
// the block is idle. One request is worked at a time; in_stall is high while
// a request is in progress. Configuration is written through cfg_we,
// cfg_index and cfg_wdata while the block is idle; nothing in the block enforces this.
// Allocate scans the N blocks from the allocation pointer (at most two
// passes). Victim pick averages the wear of the eligible blocks among the T
// in use with one divide, then reads each block with one more divide per
// eligible block and another for a block given the wear boost; all of this
// shares the one-bit-per-cycle divider and the single table read port.
// After reset all table entries are cleared in one pass, during which
// in_stall stays high. When the receiver stalls, the result is held and the
// next result waits in the block until the transfer is done.
// ----------------------------------------------------------------------------
module flash_block_wear_gc_manager_unit import gwm_pkg::*; #(
	parameter int unsigned MAX_BLOCKS = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [9:0]  block_index,
	input  wire logic [15:0] wear_cnt,
	input  wire logic [20:0] live_cnt,
	input  wire logic [20:0] dead_cnt,
	input  wire logic        is_bad,
	input  wire logic        is_reserved,
	input  wire logic        is_retired,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             status,
	output logic [9:0]       chosen_block,
	output logic [31:0]      victim_score,
	output logic             checkpoint_dirty,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [20:0] cfg_wdata
);

	localparam int unsigned AW = $clog2(MAX_BLOCKS);
	localparam int unsigned SW = 17 + AW;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RET   = 4'd1;
	localparam logic [3:0] S_AREAD = 4'd2;
	localparam logic [3:0] S_AEVAL = 4'd3;
	localparam logic [3:0] S_VSR   = 4'd4;
	localparam logic [3:0] S_VSE   = 4'd5;
	localparam logic [3:0] S_VAVG  = 4'd6;
	localparam logic [3:0] S_VR    = 4'd7;
	localparam logic [3:0] S_VE    = 4'd8;
	localparam logic [3:0] S_VD1   = 4'd9;
	localparam logic [3:0] S_VMUL  = 4'd10;
	localparam logic [3:0] S_VDS   = 4'd11;
	localparam logic [3:0] S_VD2   = 4'd12;
	localparam logic [3:0] S_VACC  = 4'd13;
	localparam logic [3:0] S_POST  = 4'd14;

	logic [3:0]    state_q;
	logic [10:0]   tot_cfg_q;
	logic [20:0]   es_q;
	logic [AW-1:0] ptr_q;
	logic          ckpt_q;
	logic [AW-1:0] idx_q;
	logic          ret_ok_q;
	logic [AW:0]   b_q;
	logic [AW:0]   end_q;
	logic          phase_q;
	logic          found_q;
	logic [AW-1:0] best_q;
	logic [15:0]   best_ec_q;
	logic [SW-1:0] sum_q;
	logic [AW:0]   cnt_q;
	logic [15:0]   avg_q;
	logic [36:0]   prod_q;
	logic [40:0]   s_q;
	logic [31:0]   best_score_q;
	logic          res_status_q;
	logic [9:0]    res_chosen_q;
	logic [31:0]   res_score_q;
	logic          out_valid_q;
	logic          status_q;
	logic [9:0]    chosen_q;
	logic [31:0]   score_q;
	logic          ckpt_out_q;

	logic              accept;
	logic              clearing;
	logic [AW:0]       tot;
	logic              in_range;
	mem_ctl_t          mctl;
	logic [AW-1:0]     maddr;
	entry_t            mwdata;
	entry_t            rd;
	logic              div_start;
	logic [DIV_NW-1:0] div_num;
	logic [DIV_DW-1:0] div_den;
	logic              div_done;
	logic [DIV_NW-1:0] div_quot;
	logic              elig;
	logic [21:0]       num1;
	logic [AW-1:0]     start_ptr;
	logic [AW:0]       next_ptr;
	logic [AW:0]       wrap_end;
	logic [31:0]       sc;
	logic              boost;

	assign tot = (32'(tot_cfg_q) > 32'(MAX_BLOCKS)) ? (AW+1)'(MAX_BLOCKS)
	                                                 : (AW+1)'(tot_cfg_q);
	assign in_range  = 32'(block_index) < 32'(MAX_BLOCKS);
	assign in_stall  = (state_q != S_IDLE) || clearing;
	assign accept    = in_valid && !in_stall;
	assign elig      = !rd.bad && !rd.rsv && !rd.ret && (rd.live < es_q);
	assign num1      = {1'b0, rd.dead} + {1'b0, es_q} - {1'b0, rd.live};
	assign start_ptr = (ptr_q == '0) ? AW'(1) : ptr_q;
	assign next_ptr  = {1'b0, best_q} + 1'b1;
	assign wrap_end  = ({1'b0, ptr_q} < tot) ? {1'b0, ptr_q} : tot;
	assign sc        = (s_q > 41'(SCORE_MAX)) ? SCORE_MAX : s_q[31:0];
	assign boost     = (rd.wear > avg_q) && (avg_q != '0) && (rd.live != '0);

	always_comb begin
		mctl      = '0;
		maddr     = b_q[AW-1:0];
		mwdata    = rd;
		div_start = 1'b0;
		div_num   = DIV_NW'(sum_q);
		div_den   = DIV_DW'(cnt_q);
		unique case (state_q)
			S_IDLE: begin
				maddr   = AW'(block_index);
				mctl.wr = accept && (req_type == REQ_WRITE) && in_range;
				mctl.rd = accept && (req_type == REQ_RETIRE);
				mwdata  = '{wear: wear_cnt, live: live_cnt, dead: dead_cnt,
				            bad: is_bad, rsv: is_reserved, ret: is_retired};
			end
			S_RET: begin
				maddr      = idx_q;
				mctl.wr    = ret_ok_q;
				mwdata.ret = 1'b1;
			end
			S_AREAD, S_VR: begin
				mctl.rd = b_q < end_q;
			end
			S_VSR: begin
				mctl.rd   = b_q < end_q;
				div_start = !(b_q < end_q) && (cnt_q != '0);
			end
			S_VE: begin
				div_start = elig;
				div_num   = DIV_NW'(num1);
				div_den   = DIV_DW'({1'b0, rd.wear} + 17'd1);
			end
			S_VDS: begin
				div_start = 1'b1;
				div_num   = DIV_NW'(prod_q);
				div_den   = DIV_DW'(avg_q);
			end
			default: begin
			end
		endcase
	end

	gwm_tbl #(.DEPTH(MAX_BLOCKS), .AW(AW)) u_tbl (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mctl),
		.addr     (maddr),
		.wdata    (mwdata),
		.rdata    (rd),
		.clearing (clearing)
	);

	gwm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tot_cfg_q   <= '0;
			es_q        <= ERASE_RESET;
			ptr_q       <= '0;
			ckpt_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_TOTAL: tot_cfg_q <= cfg_wdata[10:0];
					CFG_ERASE: es_q      <= cfg_wdata;
				endcase
			end
			if (state_q == S_POST && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req_type)
							REQ_WRITE: state_q <= S_POST;
							REQ_ALLOC: begin
								ptr_q   <= start_ptr;
								state_q <= S_AREAD;
							end
							REQ_VICTIM: begin
								state_q <= (tot == '0 || es_q == '0) ? S_POST : S_VSR;
							end
							REQ_RETIRE: begin
								ckpt_q  <= 1'b1;
								state_q <= S_RET;
							end
						endcase
					end
				end
				S_RET: state_q <= S_POST;
				S_AREAD: begin
					if (b_q < end_q) begin
						state_q <= S_AEVAL;
					end else if (!phase_q && !found_q) begin
						// wrap over 1 .. pointer-1, capped at the table size
					end else begin
						if (found_q) begin
							ptr_q <= (next_ptr >= tot) ? AW'(1) : next_ptr[AW-1:0];
						end
						state_q <= S_POST;
					end
				end
				S_AEVAL: state_q <= S_AREAD;
				S_VSR: begin
					if (b_q < end_q) begin
						state_q <= S_VSE;
					end else begin
						state_q <= (cnt_q == '0) ? S_POST : S_VAVG;
					end
				end
				S_VSE: state_q <= S_VSR;
				S_VAVG: if (div_done) state_q <= S_VR;
				S_VR: begin
					state_q <= (b_q < end_q) ? S_VE : S_POST;
				end
				S_VE: state_q <= elig ? S_VD1 : S_VR;
				S_VD1: begin
					if (div_done) begin
						state_q <= boost ? S_VMUL : S_VACC;
					end
				end
				S_VMUL: state_q <= S_VDS;
				S_VDS: state_q <= S_VD2;
				S_VD2: if (div_done) state_q <= S_VACC;
				S_VACC: state_q <= S_VR;
				S_POST: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				idx_q        <= AW'(block_index);
				ret_ok_q     <= 32'(block_index) < 32'(tot);
				res_status_q <= 1'b0;
				res_chosen_q <= '0;
				res_score_q  <= '0;
				found_q      <= 1'b0;
				phase_q      <= 1'b0;
				best_ec_q    <= 16'hFFFF;
				sum_q        <= '0;
				cnt_q        <= '0;
				end_q        <= tot;
				if (req_type == REQ_ALLOC) begin
					b_q <= {1'b0, start_ptr};
				end else begin
					b_q <= '0;
				end
				if (req_type == REQ_VICTIM && (tot == '0 || es_q == '0)) begin
					res_status_q <= 1'b1;
				end
			end
			S_AREAD: begin
				if (!(b_q < end_q)) begin
					if (!phase_q && !found_q) begin
						phase_q <= 1'b1;
						b_q     <= (AW+1)'(1);
						end_q   <= wrap_end;
					end else if (found_q) begin
						res_chosen_q <= 10'(best_q);
					end else begin
						res_status_q <= 1'b1;
					end
				end
			end
			S_AEVAL: begin
				if (!rd.bad && !rd.rsv && rd.wear < best_ec_q) begin
					best_ec_q <= rd.wear;
					best_q    <= b_q[AW-1:0];
					found_q   <= 1'b1;
				end
				b_q <= b_q + 1'b1;
			end
			S_VSR: begin
				if (!(b_q < end_q) && cnt_q == '0) begin
					res_status_q <= 1'b1;
				end
			end
			S_VSE: begin
				if (elig) begin
					sum_q <= sum_q + SW'(rd.wear);
					cnt_q <= cnt_q + 1'b1;
				end
				b_q <= b_q + 1'b1;
			end
			S_VAVG: begin
				if (div_done) begin
					avg_q        <= div_quot[15:0];
					b_q          <= '0;
					best_score_q <= '0;
				end
			end
			S_VR: begin
				if (!(b_q < end_q)) begin
					if (found_q) begin
						res_chosen_q <= 10'(best_q);
						res_score_q  <= best_score_q;
					end else begin
						res_status_q <= 1'b1;
					end
				end
			end
			S_VE: begin
				if (!elig) begin
					b_q <= b_q + 1'b1;
				end
			end
			S_VD1: if (div_done) s_q <= 41'(div_quot);
			S_VMUL: prod_q <= 37'(rd.wear - avg_q) * 37'(es_q);
			S_VD2: if (div_done) s_q <= s_q + 41'(div_quot);
			S_VACC: begin
				// first maximum wins, zero score skipped
				if (sc != '0 && (!found_q || sc > best_score_q)) begin
					best_q       <= b_q[AW-1:0];
					best_score_q <= sc;
					found_q      <= 1'b1;
				end
				b_q <= b_q + 1'b1;
			end
			default: begin
			end
		endcase

		if (state_q == S_POST && (!out_valid_q || !out_stall)) begin
			status_q   <= res_status_q;
			chosen_q   <= res_chosen_q;
			score_q    <= res_score_q;
			ckpt_out_q <= ckpt_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign chosen_block     = chosen_q;
	assign victim_score     = score_q;
	assign checkpoint_dirty = ckpt_out_q;

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (chosen_block == '0 && victim_score == '0))
		else $error("failed request carries nonzero payload");

	a_rose_post: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == S_POST))
		else $error("result raised outside post state");

	a_ptr_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_AEVAL) |-> (ptr_q != '0))
		else $error("allocate scan with zero pointer");

endmodule
`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the block wear and garbage-collection manager.
// A clocked driver sends requests from a queue that the stimulus process
// fills. A clocked monitor checks each result against a predictor of the
// wear table, allocation pointer and victim scoring kept in this bench.
// The run steps through several table sizes and erase sizes, with random
// idle bursts on both channels and one long hold-off on the output side.
// ----------------------------------------------------------------------------
module tb;
	import gwm_pkg::*;

	localparam int NBLK = 1024;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [1:0]  req;
		logic [9:0]  idx;
		logic [15:0] ec;
		logic [20:0] live;
		logic [20:0] dead;
		logic        bad;
		logic        rsv;
		logic        ret;
	} gc_req_t;

	typedef struct {
		logic        st;
		logic [9:0]  blk;
		logic [31:0] score;
		logic        ckpt;
	} gc_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = REQ_WRITE;
	logic [9:0]  block_index = '0;
	logic [15:0] wear_cnt = '0;
	logic [20:0] live_cnt = '0;
	logic [20:0] dead_cnt = '0;
	logic        is_bad = 1'b0;
	logic        is_reserved = 1'b0;
	logic        is_retired = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        status;
	logic [9:0]  chosen_block;
	logic [31:0] victim_score;
	logic        checkpoint_dirty;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_TOTAL;
	logic [20:0] cfg_wdata = '0;

	flash_block_wear_gc_manager_unit dut (.*);

	// predictor state
	int unsigned  m_total = 0;
	int unsigned  m_erase = 4096;
	int unsigned  m_ptr = 0;
	logic         m_ckpt = 1'b0;
	logic [15:0]  m_wear [NBLK];
	logic [20:0]  m_live [NBLK];
	logic [20:0]  m_dead [NBLK];
	logic [2:0]   m_flags [NBLK];
	bit           seen [NBLK];

	gc_req_t pending_reqs [$];
	gc_res_t expected_res [$];

	int  gap_cnt = 0;
	int  stall_cnt = 0;
	int  hold_cnt = 0;
	bit  quiet = 0;
	bit  hold_req = 0;
	bit  hold_done = 0;
	int  mismatches = 0;
	int  results_seen = 0;
	int  cycles = 0;
	int  n_alloc = 0, n_victim = 0, n_write = 0, n_retire = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned eff_total();
		return (m_total < NBLK) ? m_total : NBLK;
	endfunction

	function automatic gc_res_t predict_gc(gc_req_t r);
		gc_res_t     o;
		int unsigned tot, b, start, wend, best_ec, cnt, avg, ec, live;
		longint unsigned sum, s;
		int          best;
		logic [31:0] sc, best_sc;
		o = '{st: 1'b0, blk: '0, score: '0, ckpt: 1'b0};
		tot = eff_total();
		best = -1;
		case (r.req)
			REQ_WRITE: begin
				m_wear[r.idx] = r.ec;
				m_live[r.idx] = r.live;
				m_dead[r.idx] = r.dead;
				m_flags[r.idx] = {r.ret, r.rsv, r.bad};
			end
			REQ_ALLOC: begin
				if (m_ptr == 0) m_ptr = 1;
				start = m_ptr;
				best_ec = 65535;
				for (b = start; b < tot; b++)
					if (m_flags[b][1:0] == 2'b00 && m_wear[b] < best_ec) begin
						best_ec = m_wear[b];
						best = b;
					end
				if (best < 0) begin
					wend = (start < tot) ? start : tot;
					for (b = 1; b < wend; b++)
						if (m_flags[b][1:0] == 2'b00 && m_wear[b] < best_ec) begin
							best_ec = m_wear[b];
							best = b;
						end
				end
				if (best < 0) o.st = 1'b1;
				else begin
					o.blk = 10'(best);
					m_ptr = best + 1;
					if (m_ptr >= tot) m_ptr = 1;
				end
			end
			REQ_VICTIM: begin
				sum = 0;
				cnt = 0;
				best_sc = 0;
				if (tot != 0 && m_erase != 0) begin
					for (b = 0; b < tot; b++)
						if (m_flags[b] == 3'b000 && m_live[b] < m_erase) begin
							sum += m_wear[b];
							cnt++;
						end
					if (cnt != 0) begin
						avg = 32'(sum / cnt);
						for (b = 0; b < tot; b++) begin
							if (m_flags[b] != 3'b000 || m_live[b] >= m_erase) continue;
							live = m_live[b];
							ec = m_wear[b];
							s = (longint'(m_dead[b]) + longint'(m_erase - live)) /
								(longint'(ec) + 1);
							if (ec > avg && avg > 0 && live > 0)
								s += (longint'(ec - avg) * longint'(m_erase)) / longint'(avg);
							sc = (s > 64'hFFFF_FFFF) ? SCORE_MAX : s[31:0];
							if (sc == 0) continue;
							if (best < 0 || sc > best_sc) begin
								best = b;
								best_sc = sc;
							end
						end
					end
				end
				if (best < 0) o.st = 1'b1;
				else begin
					o.blk = 10'(best);
					o.score = best_sc;
				end
			end
			default: begin
				if (r.idx < tot) m_flags[r.idx][2] = 1'b1;
				m_ckpt = 1'b1;
			end
		endcase
		o.ckpt = m_ckpt;
		return o;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		gc_req_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_cnt <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				r = '{req_type, block_index, wear_cnt, live_cnt, dead_cnt,
					is_bad, is_reserved, is_retired};
				expected_res.push_back(predict_gc(r));
			end
			if (!in_valid || !in_stall) begin
				if (gap_cnt > 0) begin
					gap_cnt <= gap_cnt - 1;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0 && !quiet && $urandom_range(0, 5) == 0) begin
					gap_cnt <= $urandom_range(0, 10);
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					r = pending_reqs.pop_front();
					req_type <= r.req;
					block_index <= r.idx;
					wear_cnt <= r.ec;
					live_cnt <= r.live;
					dead_cnt <= r.dead;
					is_bad <= r.bad;
					is_reserved <= r.rsv;
					is_retired <= r.ret;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output stall: random bursts plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_cnt <= 400;
			hold_done <= 1'b1;
			out_stall <= 1'b1;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_stall <= 1'b1;
		end else if (stall_cnt > 0) begin
			stall_cnt <= stall_cnt - 1;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_cnt <= $urandom_range(0, 10);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		gc_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_res.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result: st=%0d blk=%0d score=%0d",
					status, chosen_block, victim_score);
			end else begin
				e = expected_res.pop_front();
				if (status !== e.st || chosen_block !== e.blk || victim_score !== e.score ||
					checkpoint_dirty !== e.ckpt) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected st=%0d blk=%0d score=%0d ckpt=%0d,",
							" got st=%0d blk=%0d score=%0d ckpt=%0d"},
							e.st, e.blk, e.score, e.ckpt,
							status, chosen_block, victim_score, checkpoint_dirty);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	task automatic push_req(gc_req_t r);
		pending_reqs.push_back(r);
		case (r.req)
			REQ_WRITE: begin
				n_write++;
				seen[r.idx] = 1;
			end
			REQ_ALLOC: n_alloc++;
			REQ_VICTIM: n_victim++;
			default: n_retire++;
		endcase
	endtask

	task automatic put_entry(int idx, int ec, int live, int dead, bit bad, bit rsv, bit ret);
		push_req('{REQ_WRITE, idx[9:0], ec[15:0], live[20:0], dead[20:0], bad, rsv, ret});
	endtask

	task automatic put_op(logic [1:0] op, int idx);
		push_req('{op, idx[9:0], '0, '0, '0, 1'b0, 1'b0, 1'b0});
	endtask

	function automatic gc_req_t rand_entry(int idx);
		gc_req_t r;
		r.req = REQ_WRITE;
		r.idx = idx[9:0];
		case ($urandom_range(0, 3))
			0: r.ec = 16'($urandom_range(0, 20));
			1: r.ec = 16'hFFFF;
			2: r.ec = 16'($urandom());
			default: r.ec = 16'($urandom_range(0, 3));
		endcase
		case ($urandom_range(0, 3))
			0: r.live = '0;
			1: r.live = (m_erase > 1) ? 21'($urandom_range(0, m_erase - 1)) : '0;
			2: r.live = 21'($urandom());
			default: r.live = m_erase[20:0];
		endcase
		r.dead = ($urandom_range(0, 1) != 0) ? 21'($urandom()) : 21'($urandom_range(0, 5000));
		r.bad = ($urandom_range(0, 5) == 0);
		r.rsv = ($urandom_range(0, 5) == 0);
		r.ret = ($urandom_range(0, 5) == 0);
		return r;
	endfunction

	task automatic fill_table(int tot);
		for (int b = 0; b < tot; b++)
			if (!seen[b]) push_req(rand_entry(b));
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || in_valid || expected_res.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic write_cfg(logic idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[20:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_TOTAL) m_total = val & 32'h7FF;
		else m_erase = val & 32'h1FFFFF;
	endtask

	task automatic random_phase(int tot, int n);
		int     k;
		int unsigned sel;
		fill_table(tot);
		for (k = 0; k < n; k++) begin
			sel = $urandom_range(0, 99);
			if (sel < 35) push_req(rand_entry((tot > 0 && $urandom_range(0, 3) != 0) ?
				$urandom_range(0, tot - 1) : $urandom_range(0, NBLK - 1)));
			else if (sel < 55) put_op(REQ_ALLOC, 0);
			else if (sel < 80) put_op(REQ_VICTIM, 0);
			else put_op(REQ_RETIRE, (tot > 0 && $urandom_range(0, 1) != 0) ?
				$urandom_range(0, tot - 1) : $urandom_range(0, NBLK - 1));
		end
	endtask

	int unsigned tot_list [8] = '{1, 16, 2, 9, 0, 12, 5, 16};
	int unsigned er_list [8] = '{1, 4096, 1048576, 0, 4096, 300, 65536, 4096};

	initial begin
		for (int b = 0; b < NBLK; b++) begin
			m_flags[b] = 3'b000;
			m_wear[b] = '0;
			m_live[b] = '0;
			m_dead[b] = '0;
			seen[b] = 0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		write_cfg(CFG_TOTAL, 4);
		write_cfg(CFG_ERASE, 4096);

		// nothing usable, then counts that lose, then a real pick
		put_entry(0, 5, 0, 0, 0, 0, 0);
		put_entry(1, 65535, 0, 0, 0, 0, 0);
		put_entry(2, 0, 0, 0, 1, 0, 0);
		put_entry(3, 1, 0, 0, 0, 1, 0);
		put_op(REQ_ALLOC, 0);
		put_op(REQ_VICTIM, 0);
		put_entry(1, 10, 4096, 7, 0, 0, 0);
		put_entry(3, 2, 100, 1048576, 0, 0, 0);
		put_op(REQ_ALLOC, 0);
		put_op(REQ_ALLOC, 0);
		put_op(REQ_VICTIM, 0);
		put_entry(2, 65535, 1, 2097151, 0, 0, 0);
		put_op(REQ_VICTIM, 0);
		put_op(REQ_RETIRE, 3);
		put_op(REQ_RETIRE, 1000);
		put_op(REQ_VICTIM, 0);
		put_entry(1023, 65535, 2097151, 2097151, 1, 1, 1);
		put_entry(0, 0, 4095, 0, 0, 0, 1);
		put_op(REQ_ALLOC, 0);
		put_op(REQ_VICTIM, 0);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			write_cfg(CFG_TOTAL, tot_list[ph]);
			write_cfg(CFG_ERASE, er_list[ph]);
			if (ph == 1) hold_req = 1;
			// calm finish
			if (ph == 7) quiet = 1;
			random_phase(tot_list[ph], 10);
			drain();
		end

		repeat (20) @(posedge clk);
		if (expected_res.size() != 0) mismatches++;
		$display("covered %0d writes, %0d allocates, %0d victim picks, %0d retires",
			n_write, n_alloc, n_victim, n_retire);
		$display("checked %0d results over table sizes 0 to 16, %0d mismatches",
			results_seen, mismatches);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
